// ===== hw/rtl/slcp_pkg.sv =====
// Shared types, character codes and helper functions of the serial-line CAN parser.
// Used by the top module, the front end, the queue and the back end; depends on nothing else.
package slcp_pkg;

   localparam int STD_ID_CHARS = 3;
   localparam int EXT_ID_CHARS = 8;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_BEL = 8'h07;

   localparam logic [7:0] CMD_DATA_STD = 8'h74;
   localparam logic [7:0] CMD_DATA_EXT = 8'h54;
   localparam logic [7:0] CMD_RTR_STD  = 8'h72;
   localparam logic [7:0] CMD_RTR_EXT  = 8'h52;
   localparam logic [7:0] CMD_FD_STD   = 8'h64;
   localparam logic [7:0] CMD_FD_EXT   = 8'h44;
   localparam logic [7:0] CMD_BRS_STD  = 8'h62;
   localparam logic [7:0] CMD_BRS_EXT  = 8'h42;

   localparam logic [7:0] DLC_MAX_CLASSIC = 8'h08;
   localparam logic [7:0] DLC_MAX_FD      = 8'h0F;

   typedef enum logic [2:0] {
      KIND_DATA   = 3'd0,
      KIND_NODATA = 3'd1,
      KIND_ACK    = 3'd2,
      KIND_NACK   = 3'd3,
      KIND_REJECT = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HI,
      BK_LO,
      BK_OUT
   } back_state_type;

   // One unit of work handed from the front end to the back end.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] frame_id;
      logic        ext;
      logic        rtr;
      logic        fd;
      logic        brs;
      logic [6:0]  count;
   } job_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] frame_id;
      logic        ext;
      logic        rtr;
      logic        fd;
      logic        brs;
      logic [6:0]  count;
      logic [5:0]  index;
      logic [7:0]  data;
      logic        last;
   } result_type;

   // Hex digit value with no range check; every branch wraps modulo 256.
   function automatic logic [7:0] digit_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h61) begin
         v = c - 8'h57;
      end else if (c >= 8'h41) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h30;
      end
      return v;
   endfunction

   function automatic logic [6:0] dlc_len(input logic [3:0] d);
      logic [6:0] n;
      case (d)
         4'd9:    n = 7'd12;
         4'd10:   n = 7'd16;
         4'd11:   n = 7'd20;
         4'd12:   n = 7'd24;
         4'd13:   n = 7'd32;
         4'd14:   n = 7'd48;
         4'd15:   n = 7'd64;
         default: n = {3'b000, d};
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/slcp_if.sv =====
// Valid/ready channel interfaces for the received characters and the parser results.
// Depends on nothing; the payload widths follow the block's field list.
interface slcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] frame_id;
   logic        ext_id;
   logic        is_remote;
   logic        is_fd;
   logic        bit_rate_switch;
   logic [6:0]  byte_count;
   logic [5:0]  byte_index;
   logic [7:0]  data_byte;
   logic        last;

   modport source (output valid, output kind, output frame_id, output ext_id,
                   output is_remote, output is_fd, output bit_rate_switch,
                   output byte_count, output byte_index, output data_byte,
                   output last, input ready);
   modport sink (input valid, input kind, input frame_id, input ext_id,
                 input is_remote, input is_fd, input bit_rate_switch,
                 input byte_count, input byte_index, input data_byte,
                 input last, output ready);
endinterface

// ===== hw/rtl/slcan_line_to_can_frame_parser_unit.sv =====
// Serial-line CAN receive parser: characters on req, frame results on rsp.
// Depends on slcp_pkg, slcp_if, slcp_ram, slcp_front, slcp_queue and slcp_back.
//
// The req channel carries one received character per transaction. Characters that do
// not end a line cause no result and are taken one per cycle while req is not held off.
// A carriage return or a leading BEL ends the line and queues one job, unless the line
// is longer than LINE_MAX characters; any other BEL ends the line with no job. An
// acknowledge, failure, reject or no-data result goes from the job queue into the output
// register; the first byte of a frame with payload passes from the queue through the
// states BK_HI, BK_LO and BK_OUT first. Each data byte needs two reads of the line store
// RAM, and a frame with payload holds req off from its return while the store is read.
// Acknowledge, failure, reject and no-data results need no reads and pass through the
// two-entry job queue without holding req off unless the queue is full.
// When rsp stalls, the output register holds its transaction and the back end waits;
// the front end keeps taking characters until the queue fills or a payload frame
// holds req off. Reset empties the line, the queue and the output register; the line store
// itself is not cleared, since only characters of the current line are ever read back.
module slcan_line_to_can_frame_parser_unit import slcp_pkg::*; #(
   parameter int LINE_MAX = 139
) (
   input  logic       clock,
   input  logic       reset,
   slcp_req_if.sink   req,
   slcp_rsp_if.source rsp
);

   localparam int DEPTH  = LINE_MAX + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              push;
   job_type           push_job;
   logic              q_full;
   logic              pop;
   logic              head_valid;
   job_type           head_job;
   logic              done;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   slcp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   slcp_front #(
      .LINE_MAX (LINE_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .done     (done),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data)
   );

   slcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   slcp_back #(
      .LINE_MAX (LINE_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .done       (done),
      .rsp        (rsp)
   );

endmodule

// ===== hw/rtl/slcp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module slcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 140,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/slcp_front.sv =====
// Front end: takes characters, fills the line store and decodes the header on the fly.
// Depends on slcp_pkg and slcp_req_if; pushes at most one job per finished line into the queue.
module slcp_front import slcp_pkg::*; #(
   parameter int LINE_MAX = 139,
   localparam int CNT_W  = $clog2(LINE_MAX + 2),
   localparam int ADDR_W = $clog2(LINE_MAX + 1),
   localparam int CMP_W  = CNT_W + 1
) (
   input  logic              clock,
   input  logic              reset,
   slcp_req_if.sink          req,
   input  logic              done,
   input  logic              q_full,
   output logic              push,
   output job_type           push_job,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             cmd_ok_ff, cmd_ok_in;
   logic             ext_ff, ext_in;
   logic             rtr_ff, rtr_in;
   logic             fd_ff, fd_in;
   logic             brs_ff, brs_in;
   logic [31:0]      id_ff, id_in;
   logic [7:0]       dlc_ff, dlc_in;

   logic             accept;
   logic             drop;
   logic [7:0]       dig;
   logic [CNT_W-1:0] idl;
   logic [CMP_W-1:0] len_c;
   logic [CMP_W-1:0] need_hdr;
   logic [CMP_W-1:0] need_all;
   logic [6:0]       cnt;
   logic             bad_dlc;
   job_type          eval_job;
   job_type          plain_job;

   assign req.ready = !busy_ff && !q_full;
   assign accept    = req.valid && req.ready;
   assign drop      = count_ff > CNT_W'(LINE_MAX);
   assign dig       = digit_of(req.rx_byte);
   assign idl       = ext_ff ? CNT_W'(EXT_ID_CHARS) : CNT_W'(STD_ID_CHARS);

   assign wr_en   = accept && !drop;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = req.rx_byte;

   // The header registers are complete by the time a return reaches a line that is
   // long enough; shorter lines are rejected before their contents matter.
   always_comb begin
      len_c    = CMP_W'(count_ff);
      need_hdr = CMP_W'(idl) + CMP_W'(2);
      cnt      = dlc_len(dlc_ff[3:0]);
      need_all = need_hdr + CMP_W'({cnt, 1'b0});
      bad_dlc  = fd_ff ? (dlc_ff > DLC_MAX_FD) : (dlc_ff > DLC_MAX_CLASSIC);

      plain_job      = '0;
      plain_job.kind = KIND_REJECT;

      eval_job          = plain_job;
      if (cmd_ok_ff && (len_c >= need_hdr) && !bad_dlc) begin
         eval_job.frame_id = id_ff;
         eval_job.ext      = ext_ff;
         eval_job.rtr      = rtr_ff;
         eval_job.fd       = fd_ff;
         eval_job.brs      = brs_ff;
         eval_job.count    = cnt;
         if (rtr_ff || (cnt == 7'd0)) begin
            eval_job.kind = KIND_NODATA;
         end else if (len_c < need_all) begin
            eval_job = plain_job;
         end else begin
            eval_job.kind = KIND_DATA;
         end
      end

      push     = 1'b0;
      push_job = plain_job;
      count_in = count_ff;
      if (accept) begin
         if (drop) begin
            count_in = '0;
         end else if (req.rx_byte == CH_CR) begin
            count_in = '0;
            push     = 1'b1;
            if (count_ff == '0) begin
               push_job.kind = KIND_ACK;
            end else begin
               push_job = eval_job;
            end
         end else if (req.rx_byte == CH_BEL) begin
            count_in      = '0;
            push          = (count_ff == '0);
            push_job.kind = KIND_NACK;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end

      busy_in = busy_ff;
      if (push && (push_job.kind == KIND_DATA)) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      cmd_ok_in = cmd_ok_ff;
      ext_in    = ext_ff;
      rtr_in    = rtr_ff;
      fd_in     = fd_ff;
      brs_in    = brs_ff;
      id_in     = id_ff;
      dlc_in    = dlc_ff;
      if (accept && !drop) begin
         if (count_ff == '0) begin
            cmd_ok_in = 1'b1;
            ext_in    = 1'b0;
            rtr_in    = 1'b0;
            fd_in     = 1'b0;
            brs_in    = 1'b0;
            id_in     = '0;
            case (req.rx_byte)
               CMD_DATA_STD: ;
               CMD_DATA_EXT: ext_in = 1'b1;
               CMD_RTR_STD:  rtr_in = 1'b1;
               CMD_RTR_EXT: begin
                  ext_in = 1'b1;
                  rtr_in = 1'b1;
               end
               CMD_FD_STD:   fd_in = 1'b1;
               CMD_FD_EXT: begin
                  ext_in = 1'b1;
                  fd_in  = 1'b1;
               end
               CMD_BRS_STD: begin
                  fd_in  = 1'b1;
                  brs_in = 1'b1;
               end
               CMD_BRS_EXT: begin
                  ext_in = 1'b1;
                  fd_in  = 1'b1;
                  brs_in = 1'b1;
               end
               default:      cmd_ok_in = 1'b0;
            endcase
         end else if (count_ff <= idl) begin
            id_in = {id_ff[27:0], 4'h0} + {24'h000000, dig};
         end else if (count_ff == idl + CNT_W'(1)) begin
            dlc_in = dig;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ok_ff <= cmd_ok_in;
      ext_ff    <= ext_in;
      rtr_ff    <= rtr_in;
      fd_ff     <= fd_in;
      brs_ff    <= brs_in;
      id_ff     <= id_in;
      dlc_ff    <= dlc_in;
   end

endmodule

// ===== hw/rtl/slcp_queue.sv =====
// Two-entry job queue between the front end and the back end.
// Depends on slcp_pkg for the job type.
module slcp_queue import slcp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output job_type head_job
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== hw/rtl/slcp_back.sv =====
// Back end: turns queued jobs into results, reading data digit pairs from the line store.
// Depends on slcp_pkg and slcp_rsp_if; owns the output register of the result channel.
module slcp_back import slcp_pkg::*; #(
   parameter int LINE_MAX = 139,
   localparam int ADDR_W = $clog2(LINE_MAX + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  job_type           head_job,
   output logic              pop,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              done,
   slcp_rsp_if.source        rsp
);

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   logic [5:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [7:0]        hi_ff, hi_in;
   logic [7:0]        byte_ff, byte_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;

   logic              out_free;
   logic              is_last;
   logic [ADDR_W-1:0] base;

   assign out_free = !out_valid_ff || rsp.ready;
   assign is_last  = ({1'b0, idx_ff} + 7'd1) == job_ff.count;
   assign base     = head_job.ext ? ADDR_W'(EXT_ID_CHARS + 2) : ADDR_W'(STD_ID_CHARS + 2);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid && (head_job.kind == KIND_DATA)) begin
               state_in = BK_HI;
            end
         end
         BK_HI:  state_in = BK_LO;
         BK_LO:  state_in = BK_OUT;
         BK_OUT: begin
            if (out_free) begin
               state_in = is_last ? BK_IDLE : BK_HI;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      done         = 1'b0;
      rd_addr      = addr_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      hi_in        = hi_ff;
      byte_in      = byte_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_in       = out_ff;
      case (state_ff)
         BK_IDLE: begin
            rd_addr = base;
            if (head_valid && (head_job.kind == KIND_DATA)) begin
               pop    = 1'b1;
               job_in = head_job;
               idx_in = '0;
            end else if (head_valid && out_free) begin
               pop             = 1'b1;
               out_valid_in    = 1'b1;
               out_in.kind     = head_job.kind;
               out_in.frame_id = head_job.frame_id;
               out_in.ext      = head_job.ext;
               out_in.rtr      = head_job.rtr;
               out_in.fd       = head_job.fd;
               out_in.brs      = head_job.brs;
               out_in.count    = head_job.count;
               out_in.index    = '0;
               out_in.data     = '0;
               out_in.last     = 1'b1;
            end
         end
         BK_HI: begin
            hi_in   = digit_of(rd_data);
            rd_addr = addr_ff + ADDR_W'(1);
         end
         BK_LO: begin
            byte_in = {hi_ff[3:0], 4'h0} + digit_of(rd_data);
         end
         BK_OUT: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_in.kind     = KIND_DATA;
               out_in.frame_id = job_ff.frame_id;
               out_in.ext      = job_ff.ext;
               out_in.rtr      = job_ff.rtr;
               out_in.fd       = job_ff.fd;
               out_in.brs      = job_ff.brs;
               out_in.count    = job_ff.count;
               out_in.index    = idx_ff;
               out_in.data     = byte_ff;
               out_in.last     = is_last;
               idx_in          = idx_ff + 6'd1;
               done            = is_last;
               rd_addr         = addr_ff + ADDR_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The address register follows the read address, so a stalled read repeats itself.
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      addr_ff <= rd_addr;
      hi_ff   <= hi_in;
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.kind            = out_ff.kind;
   assign rsp.frame_id        = out_ff.frame_id;
   assign rsp.ext_id          = out_ff.ext;
   assign rsp.is_remote       = out_ff.rtr;
   assign rsp.is_fd           = out_ff.fd;
   assign rsp.bit_rate_switch = out_ff.brs;
   assign rsp.byte_count      = out_ff.count;
   assign rsp.byte_index      = out_ff.index;
   assign rsp.data_byte       = out_ff.data;
   assign rsp.last            = out_ff.last;

endmodule
